// ===== hw/rtl/tuves_pkg.sv =====
package tuves_pkg;

  localparam int COORD_BITS   = 32;
  localparam int SPAN_BITS    = 31;
  localparam int SLOT_BITS    = 2;
  localparam int CORNERS      = 3;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_U_SPAN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_V_SPAN = 2'd1;

  // slot code that carries no corner
  localparam logic [SLOT_BITS-1:0] SLOT_NONE = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] vertex_slot;
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               pos_z;
    coord_t               tex_u;
    coord_t               tex_v;
  } vertex_t;

  typedef struct packed {
    logic                 which_triangle;
    logic [SLOT_BITS-1:0] out_slot;
    coord_t               out_x;
    coord_t               out_y;
    coord_t               out_z;
    coord_t               out_u;
    coord_t               out_v;
    logic                 split_done;
    logic [SLOT_BITS-1:0] cut_start;
    logic [SLOT_BITS-1:0] cut_end;
    logic                 last_vertex;
  } result_t;

endpackage

// ===== hw/rtl/vertex_if.sv =====
interface vertex_if import tuves_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/result_if.sv =====
interface result_if import tuves_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/triangle_uv_edge_splitter.sv =====
// Longest-edge bisection of one triangle in uv space. Send the three corners as vertex
// requests (slot 3 is dropped); the third counted request starts the split test and the
// block then takes no vertex until its results are loaded into the output register. One
// shared 32x32 squarer and a three-entry corner store with a single registered read port
// do the work: the edge scan reads both corners of each edge, squares the u and v spans
// in turn and compares their sum; a split then reads the cut edge's corners for the
// midpoint, and each result is a corner read and a load, held while the result side
// stalls. Results come out in corner order, the first half before the second. Write
// max_u_span and max_v_span only while no triangle is in flight.
module triangle_uv_edge_splitter import tuves_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SPAN_BITS-1:0]    cfg_data,
  vertex_if.sink                  vtx,
  result_if.source                res
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t u;
    coord_t v;
  } corner_t;

  localparam int EDGES  = 3;
  localparam int MUL_W  = 2 * COORD_BITS;
  localparam int LEN_W  = MUL_W + 1;

  localparam logic [SLOT_BITS-1:0] EDGE_FROM [EDGES] = '{2'd2, 2'd0, 2'd1};
  localparam logic [SLOT_BITS-1:0] EDGE_TO   [EDGES] = '{2'd0, 2'd1, 2'd2};
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = 2'(CORNERS - 1);
  localparam logic [1:0]           LAST_EDGE = 2'(EDGES - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDA    = 4'd1;
  localparam logic [3:0] S_RDB    = 4'd2;
  localparam logic [3:0] S_DIFF   = 4'd3;
  localparam logic [3:0] S_SQU    = 4'd4;
  localparam logic [3:0] S_SQV    = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_M_RDA  = 4'd8;
  localparam logic [3:0] S_M_RDB  = 4'd9;
  localparam logic [3:0] S_MID    = 4'd10;
  localparam logic [3:0] S_O_RD   = 4'd11;
  localparam logic [3:0] S_O_LOAD = 4'd12;

  function automatic coord_t half_sum(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    return s[COORD_BITS:1];
  endfunction

  function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? -d : d;
    return m[COORD_BITS-1:0];
  endfunction

  // control
  logic [3:0]           state;
  logic [1:0]           corners_loaded;
  logic [1:0]           edge_i;
  logic                 found;
  logic [SLOT_BITS-1:0] best_s;
  logic [SLOT_BITS-1:0] best_e;
  logic [SLOT_BITS-1:0] out_c;
  logic                 out_tri;
  logic                 out_valid;
  logic [SPAN_BITS-1:0] max_u_span;
  logic [SPAN_BITS-1:0] max_v_span;

  // datapath
  corner_t              corner_mem [CORNERS];
  corner_t              rd_q;
  logic [SLOT_BITS-1:0] rd_addr;
  corner_t              a_rec;
  corner_t              mid_rec;
  logic [COORD_BITS-1:0] du;
  logic [COORD_BITS-1:0] dv;
  logic                  cand;
  logic [MUL_W-1:0]      sq_u;
  logic [MUL_W-1:0]      sq_v;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      best;
  logic [COORD_BITS-1:0] mul_op;
  logic [MUL_W-1:0]      mul_p;
  result_t               out_data;
  corner_t               sel_rec;
  logic                  rep;
  logic                  out_last;

  logic in_accept;
  logic out_take;
  logic out_load;

  assign in_accept = vtx.valid && vtx.ready;
  assign out_take  = out_valid && res.ready;
  assign out_load  = (state == S_O_LOAD) && (!out_valid || res.ready);
  assign vtx.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.payload = out_data;

  // the one shared squarer
  assign mul_op = (state == S_SQV) ? dv : du;
  assign mul_p  = {{COORD_BITS{1'b0}}, mul_op} * {{COORD_BITS{1'b0}}, mul_op};

  always_comb begin
    case (state)
      S_RDA:    rd_addr = EDGE_FROM[edge_i];
      S_RDB:    rd_addr = EDGE_TO[edge_i];
      S_M_RDA:  rd_addr = best_s;
      S_M_RDB:  rd_addr = best_e;
      S_O_RD:   rd_addr = out_c;
      S_O_LOAD: rd_addr = out_c;
      default:  rd_addr = '0;
    endcase
  end

  assign rep      = found && (out_tri ? (out_c == best_e) : (out_c == best_s));
  assign sel_rec  = rep ? mid_rec : rd_q;
  assign out_last = (out_c == LAST_SLOT) && (out_tri || !found);

  // corner store: written on load, one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && vtx.payload.vertex_slot != SLOT_NONE) begin
      corner_mem[vtx.payload.vertex_slot] <= '{x: vtx.payload.pos_x, y: vtx.payload.pos_y,
                                               z: vtx.payload.pos_z, u: vtx.payload.tex_u,
                                               v: vtx.payload.tex_v};
    end
    rd_q <= corner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_RDB: a_rec <= rd_q;
      S_DIFF: begin
        du   <= abs_diff(rd_q.u, a_rec.u);
        dv   <= abs_diff(rd_q.v, a_rec.v);
        cand <= (abs_diff(rd_q.u, a_rec.u) > {1'b0, max_u_span}) ||
                (abs_diff(rd_q.v, a_rec.v) > {1'b0, max_v_span});
      end
      S_SQU: sq_u <= mul_p;
      S_SQV: sq_v <= mul_p;
      S_SUM: len  <= {1'b0, sq_u} + {1'b0, sq_v};
      S_M_RDB: a_rec <= rd_q;
      S_MID: begin
        mid_rec.x <= half_sum(a_rec.x, rd_q.x);
        mid_rec.y <= half_sum(a_rec.y, rd_q.y);
        mid_rec.z <= half_sum(a_rec.z, rd_q.z);
        mid_rec.u <= half_sum(a_rec.u, rd_q.u);
        mid_rec.v <= half_sum(a_rec.v, rd_q.v);
      end
      S_O_LOAD: begin
        if (!out_valid || res.ready) begin
          out_data.which_triangle <= out_tri;
          out_data.out_slot       <= out_c;
          out_data.out_x          <= sel_rec.x;
          out_data.out_y          <= sel_rec.y;
          out_data.out_z          <= sel_rec.z;
          out_data.out_u          <= sel_rec.u;
          out_data.out_v          <= sel_rec.v;
          out_data.split_done     <= found;
          out_data.cut_start      <= best_s;
          out_data.cut_end        <= best_e;
          out_data.last_vertex    <= out_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      corners_loaded <= '0;
      edge_i         <= '0;
      found          <= 1'b0;
      best_s         <= '0;
      best_e         <= '0;
      best           <= '0;
      out_c          <= '0;
      out_tri        <= 1'b0;
      out_valid      <= 1'b0;
      max_u_span     <= '0;
      max_v_span     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_U_SPAN: max_u_span <= cfg_data;
          REG_MAX_V_SPAN: max_v_span <= cfg_data;
          default: ;
        endcase
      end

      // a new load keeps the register full even when the old result leaves
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept && vtx.payload.vertex_slot != SLOT_NONE) begin
            if (corners_loaded == 2'd2) begin
              corners_loaded <= '0;
              edge_i         <= '0;
              found          <= 1'b0;
              best_s         <= '0;
              best_e         <= '0;
              best           <= '0;
              state          <= S_RDA;
            end else begin
              corners_loaded <= corners_loaded + 2'd1;
            end
          end
        end
        S_RDA:  state <= S_RDB;
        S_RDB:  state <= S_DIFF;
        S_DIFF: state <= S_SQU;
        S_SQU:  state <= S_SQV;
        S_SQV:  state <= S_SUM;
        S_SUM:  state <= S_CMP;
        S_CMP: begin
          // strict compare: the earliest edge keeps a tie
          if (cand && len > best) begin
            best   <= len;
            best_s <= EDGE_FROM[edge_i];
            best_e <= EDGE_TO[edge_i];
            found  <= 1'b1;
          end
          if (edge_i == LAST_EDGE) begin
            out_c   <= '0;
            out_tri <= 1'b0;
            state   <= (cand && len > best) || found ? S_M_RDA : S_O_RD;
          end else begin
            edge_i <= edge_i + 2'd1;
            state  <= S_RDA;
          end
        end
        S_M_RDA: state <= S_M_RDB;
        S_M_RDB: state <= S_MID;
        S_MID:   state <= S_O_RD;
        S_O_RD:  state <= S_O_LOAD;
        S_O_LOAD: begin
          // hold until the output register is free
          if (out_load) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              if (out_c == LAST_SLOT) begin
                out_c   <= '0;
                out_tri <= 1'b1;
              end else begin
                out_c <= out_c + 2'd1;
              end
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mid_needs_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> found)
    else $error("midpoint computed without a split edge");

  a_second_half_only_on_split: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.which_triangle) |-> res.payload.split_done)
    else $error("second triangle emitted without a split");

  a_cut_edge_distinct: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.split_done) |-> (res.payload.cut_start != res.payload.cut_end))
    else $error("split edge has equal corners");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    corners_loaded != 2'd3)
    else $error("corner count out of range");

  a_load_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_O_LOAD && !out_valid) |=> out_valid)
    else $error("result not loaded into free output register");

endmodule

// ===== sim/triangle_uv_edge_splitter_tb.sv =====
module triangle_uv_edge_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tuves_pkg::*;

  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam logic [SPAN_BITS-1:0] SPAN_MAX = '1;
  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SPAN_BITS-1:0]    cfg_data;

  vertex_if vtx_ch ();
  result_if res_ch ();

  triangle_uv_edge_splitter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx_ch),
    .res       (res_ch)
  );

  always #5 clk = ~clk;

  // bisection predictor state
  coord_t               corner_pos [3][3] = '{default: '0};
  coord_t               corner_uv  [3][2] = '{default: '0};
  bit                   slot_loaded [3]   = '{default: 1'b0};
  int                   corners_seen      = 0;
  logic [SPAN_BITS-1:0] u_limit           = '0;
  logic [SPAN_BITS-1:0] v_limit           = '0;
  result_t              due_vertices [$];

  int  errors         = 0;
  int  requests_sent  = 0;
  int  triangles_done = 0;
  int  splits_done    = 0;
  int  results_seen   = 0;
  int  holds_taken    = 0;
  int  hold_request   = 0;
  bit  src_gaps       = 1'b1;
  bit  res_gaps       = 1'b1;

  function automatic logic [32:0] uv_span(coord_t a, coord_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // floor of the mean, taken on a sum one bit wider
  function automatic coord_t halfway(coord_t a, coord_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    s = s >>> 1;
    return s[31:0];
  endfunction

  function automatic void split_expect(vertex_t v);
    int               s, t, e, c, half, best_s, best_e;
    bit               found, rep;
    logic [32:0]      du, dv;
    logic [66:0]      len, best;
    coord_t           mid_pos [3];
    coord_t           mid_uv [2];
    result_t          r;
    if (v.vertex_slot == SLOT_NONE) return;
    corner_pos[v.vertex_slot] = '{v.pos_x, v.pos_y, v.pos_z};
    corner_uv[v.vertex_slot]  = '{v.tex_u, v.tex_v};
    slot_loaded[v.vertex_slot] = 1'b1;
    if (corners_seen < 2) begin
      corners_seen++;
      return;
    end
    corners_seen = 0;

    // edges (2,0), (0,1), (1,2); an equal length keeps the earlier edge
    found  = 1'b0;
    best   = '0;
    best_s = 0;
    best_e = 0;
    for (e = 0; e < CORNERS; e++) begin
      s  = (e + 2) % CORNERS;
      t  = e;
      du = uv_span(corner_uv[t][0], corner_uv[s][0]);
      dv = uv_span(corner_uv[t][1], corner_uv[s][1]);
      if (du > 33'(u_limit) || dv > 33'(v_limit)) begin
        len = 67'(du) * 67'(du) + 67'(dv) * 67'(dv);
        if (len > best) begin
          best   = len;
          best_s = s;
          best_e = t;
          found  = 1'b1;
        end
      end
    end

    for (c = 0; c < 3; c++) mid_pos[c] = halfway(corner_pos[best_s][c], corner_pos[best_e][c]);
    for (c = 0; c < 2; c++) mid_uv[c] = halfway(corner_uv[best_s][c], corner_uv[best_e][c]);

    triangles_done++;
    if (found) splits_done++;
    for (half = 0; half <= int'(found); half++) begin
      for (c = 0; c < CORNERS; c++) begin
        rep              = found && (c == (half != 0 ? best_e : best_s));
        r.which_triangle = half[0];
        r.out_slot       = c[1:0];
        r.out_x          = rep ? mid_pos[0] : corner_pos[c][0];
        r.out_y          = rep ? mid_pos[1] : corner_pos[c][1];
        r.out_z          = rep ? mid_pos[2] : corner_pos[c][2];
        r.out_u          = rep ? mid_uv[0]  : corner_uv[c][0];
        r.out_v          = rep ? mid_uv[1]  : corner_uv[c][1];
        r.split_done     = found;
        r.cut_start      = found ? best_s[1:0] : '0;
        r.cut_end        = found ? best_e[1:0] : '0;
        r.last_vertex    = (c == CORNERS - 1) && (half == int'(found));
        due_vertices.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (due_vertices.size() == 0) begin
        $error("result with nothing pending: %p", res_ch.payload);
        errors++;
      end else begin
        want = due_vertices.pop_front();
        check_field("which_triangle", want.which_triangle, res_ch.payload.which_triangle);
        check_field("out_slot", want.out_slot, res_ch.payload.out_slot);
        check_field("out_x", want.out_x, res_ch.payload.out_x);
        check_field("out_y", want.out_y, res_ch.payload.out_y);
        check_field("out_z", want.out_z, res_ch.payload.out_z);
        check_field("out_u", want.out_u, res_ch.payload.out_u);
        check_field("out_v", want.out_v, res_ch.payload.out_v);
        check_field("split_done", want.split_done, res_ch.payload.split_done);
        check_field("cut_start", want.cut_start, res_ch.payload.cut_start);
        check_field("cut_end", want.cut_end, res_ch.payload.cut_end);
        check_field("last_vertex", want.last_vertex, res_ch.payload.last_vertex);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls plus the long hold-off on request
  always @(negedge clk) begin : drive_ready
    int hold_left;
    int stall_left;
    if (rst) begin
      hold_left  = 0;
      stall_left = 0;
      res_ch.ready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
        holds_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (res_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return coord_t'($urandom_range(0, 4095)) - 2048;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // uv offset from a shared base, often right at the span limit
  function automatic coord_t near_limit(coord_t base, logic [SPAN_BITS-1:0] lim);
    coord_t step;
    case ($urandom_range(0, 5))
      0, 1:    step = coord_t'($urandom_range(0, 64)) - 32;
      2, 3:    step = coord_t'({1'b0, lim}) + coord_t'($urandom_range(0, 2)) - 1;
      4:       step = coord_t'($urandom);
      default: return rand_coord();
    endcase
    if ($urandom_range(0, 1) != 0) step = -step;
    return base + step;
  endfunction

  function automatic vertex_t make_vertex(logic [SLOT_BITS-1:0] slot, coord_t bu, coord_t bv);
    vertex_t v;
    v.vertex_slot = slot;
    v.pos_x       = rand_coord();
    v.pos_y       = rand_coord();
    v.pos_z       = rand_coord();
    v.tex_u       = near_limit(bu, u_limit);
    v.tex_v       = near_limit(bv, v_limit);
    return v;
  endfunction

  function automatic vertex_t corner_item(logic [SLOT_BITS-1:0] slot, coord_t x, coord_t y,
                                          coord_t z, coord_t u, coord_t v);
    vertex_t item;
    item = '{vertex_slot: slot, pos_x: x, pos_y: y, pos_z: z, tex_u: u, tex_v: v};
    return item;
  endfunction

  // call at a falling edge; returns at the falling edge after the accept
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx_ch.valid   <= 1'b1;
    vtx_ch.payload <= v;
    do @(posedge clk); while (!vtx_ch.ready);
    requests_sent++;
    split_expect(v);
    @(negedge clk);
  endtask

  task automatic wait_drained(int settle);
    vtx_ch.valid <= 1'b0;
    do @(negedge clk); while (due_vertices.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SPAN_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_MAX_U_SPAN) u_limit = data;
    else if (idx == REG_MAX_V_SPAN) v_limit = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(logic [SPAN_BITS-1:0] u, logic [SPAN_BITS-1:0] v);
    wait_drained(40);
    write_reg(REG_MAX_U_SPAN, u);
    write_reg(REG_MAX_V_SPAN, v);
  endtask

  // mostly whole triangles in shuffled corner order; some repeat a slot or carry a slot-3 request
  task automatic send_triangle();
    int     order [3];
    int     k, j, tmp, noise_at, shape;
    coord_t bu, bv;
    bu    = rand_coord();
    bv    = rand_coord();
    order = '{0, 1, 2};
    for (k = 2; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    shape = $urandom_range(0, 99);
    if (shape < 8 && slot_loaded[0] && slot_loaded[1] && slot_loaded[2]) begin
      for (k = 0; k < 3; k++) order[k] = $urandom_range(0, 2);
    end
    noise_at = (shape >= 8 && shape < 16) ? $urandom_range(0, 2) : -1;
    for (k = 0; k < 3; k++) begin
      if (k == noise_at) send_vertex(make_vertex(SLOT_NONE, bu, bv));
      send_vertex(make_vertex(order[k][1:0], bu, bv));
    end
  endtask

  task automatic test_directed();
    // spare indexes must leave both limits at zero
    write_reg(REG_SPARE_A, SPAN_MAX);
    write_reg(REG_SPARE_B, 31'h155);

    // equal uv everywhere: no candidate edge
    send_vertex(corner_item(2'd0, COORD_MAX, COORD_MIN, 0, 5, 5));
    send_vertex(corner_item(2'd1, -1, 0, COORD_MAX, 5, 5));
    send_vertex(corner_item(2'd2, COORD_MIN, -1, 7, 5, 5));

    // full-range uv, odd negative position sums, corners out of order
    send_vertex(corner_item(2'd2, 100, -7, 1, 0, COORD_MIN));
    send_vertex(corner_item(2'd0, -3, COORD_MIN, COORD_MAX, COORD_MIN, 0));
    send_vertex(corner_item(2'd1, 0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));

    // equal lengths on (2,0) and (0,1), with a dropped slot-3 request inside
    send_vertex(corner_item(2'd0, -1, -2, 3, 0, 0));
    send_vertex(corner_item(SLOT_NONE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_vertex(corner_item(2'd1, 5, 5, 5, 3, 4));
    send_vertex(corner_item(2'd2, -6, 9, -9, 4, 3));

    // slot 1 twice: slot 2 keeps its earlier corner
    send_vertex(corner_item(2'd1, 11, 12, 13, -20, 40));
    send_vertex(corner_item(2'd0, COORD_MIN, COORD_MIN, COORD_MIN, 7, -7));
    send_vertex(corner_item(2'd1, -11, -12, -13, 20, -40));

    set_limits(SPAN_MAX, SPAN_MAX);
    send_vertex(corner_item(2'd0, 1, 2, 3, COORD_MIN, 0));
    send_vertex(corner_item(2'd1, -1, -2, -3, COORD_MAX, 0));
    send_vertex(corner_item(2'd2, 9, 9, 9, 0, 0));
    send_vertex(corner_item(2'd0, 1, 2, 3, 1000, -1000));
    send_vertex(corner_item(2'd1, 4, 5, 6, -1000, 1000));
    send_vertex(corner_item(2'd2, 7, 8, 9, 0, 0));

    // u span exactly at the limit, then one past it
    set_limits(31'd10, SPAN_MAX);
    send_vertex(corner_item(2'd0, 0, 0, 0, 0, 0));
    send_vertex(corner_item(2'd1, 2, 2, 2, 10, 0));
    send_vertex(corner_item(2'd2, 4, 4, 4, 5, 0));
    send_vertex(corner_item(2'd0, 0, 0, 0, 0, 0));
    send_vertex(corner_item(2'd1, 3, 3, 3, 11, 0));
    send_vertex(corner_item(2'd2, 4, 4, 4, 5, 0));
  endtask

  task automatic test_limit_sweep();
    logic [SPAN_BITS-1:0] u_set [6];
    logic [SPAN_BITS-1:0] v_set [6];
    int                   i, k;
    u_set = '{'0, SPAN_MAX, 31'd16, SPAN_MAX, 31'd256, SPAN_BITS'($urandom)};
    v_set = '{'0, SPAN_MAX, SPAN_MAX, 31'd16, 31'd256, SPAN_BITS'($urandom)};
    for (i = 0; i < 6; i++) begin
      set_limits(u_set[i], v_set[i]);
      for (k = 0; k < 8; k++) send_triangle();
    end
  endtask

  // hold the output long enough that the input stalls behind it
  task automatic test_output_hold();
    int k;
    wait_drained(1);
    hold_request = 400;
    src_gaps     = 1'b0;
    for (k = 0; k < 8; k++) send_triangle();
    src_gaps = 1'b1;
  endtask

  task automatic test_pause();
    int k;
    for (k = 0; k < 4; k++) send_triangle();
    wait_drained(1);
    for (k = 0; k < 4; k++) send_triangle();
  endtask

  task automatic test_random();
    int seg, k;
    for (seg = 0; seg < 5; seg++) begin
      if ($urandom_range(0, 3) == 0) begin
        set_limits(SPAN_BITS'($urandom), SPAN_BITS'($urandom));
      end else begin
        set_limits(SPAN_BITS'($urandom_range(0, 4096)), SPAN_BITS'($urandom_range(0, 4096)));
      end
      for (k = 0; k < 17; k++) begin
        if (k % 6 == 0) begin
          src_gaps = $urandom_range(0, 3) != 0;
          res_gaps = $urandom_range(0, 3) != 0;
        end
        send_triangle();
      end
    end
    src_gaps = 1'b1;
    res_gaps = 1'b1;
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    vtx_ch.valid   = 1'b0;
    vtx_ch.payload = '0;
    res_ch.ready   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_limit_sweep();
    test_output_hold();
    test_pause();
    test_random();
    wait_drained(60);

    $display("Covered %0d vertex requests into %0d triangles (%0d split), %0d results checked,",
             requests_sent, triangles_done, splits_done, results_seen);
    $display("with %0d long output hold-offs and span limits from zero to full scale.",
             holds_taken);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
